// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL, included by merge_sort_engine.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/mse_pkg.sv -----
// Shared constants of the merge sort engine.
package mse_pkg;
  localparam int DATA_W        = 32;
  localparam int MAX_ITEMS_DEF = 64;
endpackage

// ----- rtl/mse_if.sv -----
// Valid/ready channels carrying input and result items of the merge sort engine.
interface mse_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [mse_pkg::DATA_W-1:0] value;
  logic                             last;
  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface mse_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [mse_pkg::DATA_W-1:0] sorted_value;
  logic                             last_out;
  logic                             overflow;
  modport source (output valid, output sorted_value, output last_out, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input last_out, input overflow,
                  output ready);
endinterface

// ----- rtl/merge_sort_engine.sv -----
// Merge sort engine: loads a list, sorts it by bottom-up merge passes, emits it in order.
// Load: items are accepted only in IDLE; the item marked last starts the sort, or goes straight to output for one item.
// Sort: ceil(log2(n)) merge passes, each a PRIME step and then MERGE, one element per cycle
// through the shared compare unit, ping-ponging between two memories with two read ports.
// Output: an OPRIME step, then one result per cycle while the receiver holds ready.
// Reset clears control state only; the memories are not cleared and need no clearing pass.
`include "assert_macros.svh"

module merge_sort_engine #(
  parameter int MAX_ITEMS = mse_pkg::MAX_ITEMS_DEF
) (
  input logic        clk,
  input logic        rst,
  mse_in_if.sink     in_ch,
  mse_out_if.source  out_ch
);

  localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int SUM_W = CNT_W + 2;
  localparam int DW    = mse_pkg::DATA_W;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_ITEMS);

  typedef enum logic [2:0] {IDLE, PRIME, MERGE, OPRIME, OUT} state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic             dropped;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] width;
  logic             src;
  logic [CNT_W-1:0] i, j, mid, hi, k, o_idx;
  logic             out_valid;
  logic signed [DW-1:0] out_value;
  logic             out_last;
  logic             out_ovf;

  logic signed [DW-1:0] bank0 [MAX_ITEMS];
  logic signed [DW-1:0] bank1 [MAX_ITEMS];
  logic signed [DW-1:0] rd0_a, rd0_b, rd1_a, rd1_b;

  logic [IDX_W-1:0]     addr_a, addr_b, waddr;
  logic signed [DW-1:0] wdata;
  logic                 we0, we1;

  logic signed [DW-1:0] head_a, head_b, pick;
  logic                 take_left, left_ok, right_ok;
  logic [CNT_W-1:0]     i_adv, j_adv;
  logic                 pair_done, pass_done;
  logic [SUM_W-1:0]     base_s, sum_w, sum_2w, n_s, w_dbl;
  logic [CNT_W-1:0]     pr_mid, pr_hi;
  logic                 in_acc, room, take_out, out_is_last;
  logic [CNT_W-1:0]     count_after;
  logic                 merge_ok;

  assign in_ch.ready         = (state == IDLE);
  assign in_acc              = in_ch.valid && in_ch.ready;
  assign room                = (count < CAP);
  assign count_after         = room ? count + CNT_W'(1) : count;

  assign out_ch.valid        = out_valid;
  assign out_ch.sorted_value = out_value;
  assign out_ch.last_out     = out_last;
  assign out_ch.overflow     = out_ovf;

  // Shared merge compare unit, pass index arithmetic and output handshake terms
  always_comb begin
    head_a    = src ? rd1_a : rd0_a;
    head_b    = src ? rd1_b : rd0_b;
    left_ok   = (i < mid);
    right_ok  = (j < hi);
    take_left = left_ok && (!right_ok || (head_a <= head_b));
    pick      = take_left ? head_a : head_b;
    i_adv     = take_left ? i + CNT_W'(1) : i;
    j_adv     = take_left ? j : j + CNT_W'(1);
    pair_done = ({1'b0, k} + (CNT_W+1)'(1)) == {1'b0, hi};
    pass_done = ({1'b0, k} + (CNT_W+1)'(1)) == {1'b0, n};
    n_s       = SUM_W'(n);
    base_s    = (state == MERGE) ? SUM_W'(hi) : '0;
    sum_w     = base_s + SUM_W'(width);
    sum_2w    = sum_w + SUM_W'(width);
    pr_mid    = (sum_w < n_s) ? sum_w[CNT_W-1:0] : n;
    pr_hi     = (sum_2w < n_s) ? sum_2w[CNT_W-1:0] : n;
    w_dbl     = SUM_W'(width) << 1;
    take_out  = (state == OUT) && (!out_valid || out_ch.ready);
    out_is_last = ({1'b0, o_idx} + (CNT_W+1)'(1)) == {1'b0, n};
    merge_ok  = (state != MERGE) || (k < n && i <= mid && j <= hi && hi <= n);
  end

  // Memory address and write selection
  always_comb begin
    addr_a = '0;
    addr_b = '0;
    we0    = 1'b0;
    we1    = 1'b0;
    waddr  = k[IDX_W-1:0];
    wdata  = pick;
    unique case (state)
      IDLE: begin
        we0   = in_acc && room;
        waddr = count[IDX_W-1:0];
        wdata = in_ch.value;
      end
      PRIME: begin
        addr_a = base_s[IDX_W-1:0];
        addr_b = pr_mid[IDX_W-1:0];
      end
      MERGE: begin
        we0 = src;
        we1 = !src;
        if (pair_done) begin
          addr_a = hi[IDX_W-1:0];
          addr_b = pr_mid[IDX_W-1:0];
        end else begin
          addr_a = i_adv[IDX_W-1:0];
          addr_b = j_adv[IDX_W-1:0];
        end
      end
      OPRIME: begin
        addr_a = '0;
      end
      OUT: begin
        addr_a = take_out ? (o_idx[IDX_W-1:0] + IDX_W'(1)) : o_idx[IDX_W-1:0];
      end
      default: begin
        addr_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we0) begin
      bank0[waddr] <= wdata;
    end
    rd0_a <= bank0[addr_a];
    rd0_b <= bank0[addr_b];
  end

  always_ff @(posedge clk) begin
    if (we1) begin
      bank1[waddr] <= wdata;
    end
    rd1_a <= bank1[addr_a];
    rd1_b <= bank1[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take_out) begin
        out_valid <= 1'b1;
        out_value <= head_a;
        out_last  <= out_is_last;
        out_ovf   <= dropped;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (in_acc) begin
            count <= count_after;
            if (!room) begin
              dropped <= 1'b1;
            end
            if (in_ch.last) begin
              n     <= count_after;
              width <= CNT_W'(1);
              src   <= 1'b0;
              state <= (count_after > CNT_W'(1)) ? PRIME : OPRIME;
            end
          end
        end
        PRIME: begin
          i     <= base_s[CNT_W-1:0];
          j     <= pr_mid;
          mid   <= pr_mid;
          hi    <= pr_hi;
          k     <= '0;
          state <= MERGE;
        end
        MERGE: begin
          k <= k + CNT_W'(1);
          if (pass_done) begin
            src   <= !src;
            width <= w_dbl[CNT_W-1:0];
            state <= (w_dbl < n_s) ? PRIME : OPRIME;
          end else if (pair_done) begin
            i   <= hi;
            j   <= pr_mid;
            mid <= pr_mid;
            hi  <= pr_hi;
          end else begin
            i <= i_adv;
            j <= j_adv;
          end
        end
        OPRIME: begin
          o_idx <= '0;
          state <= OUT;
        end
        OUT: begin
          if (take_out) begin
            o_idx <= o_idx + CNT_W'(1);
            if (out_is_last) begin
              count   <= '0;
              dropped <= 1'b0;
              state   <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  `ASSERT_ALWAYS(a_count_cap, count <= CAP, "stored count exceeds capacity")
  `ASSERT_ALWAYS(a_merge_bounds, merge_ok, "merge indexes out of range")
  `ASSERT_NEXT(a_last_blocks, in_acc && in_ch.last, !in_ch.ready, "ready after last item")
  `ASSERT_NEXT(a_out_last_idle, take_out && out_is_last, state == IDLE, "not idle after last")

endmodule

// ----- sim/merge_sort_engine_tb.sv -----
// Testbench for merge_sort_engine: random and edge-case lists checked against a sorting scoreboard.
module merge_sort_engine_tb;

  localparam int CAPACITY   = mse_pkg::MAX_ITEMS_DEF;
  localparam int RAND_ITEMS = 330;
  localparam int QUIET_MAX  = 5000;
  localparam int TAIL       = 50;

  typedef logic signed [mse_pkg::DATA_W-1:0] word_t;

  localparam word_t MIN_W = {1'b1, {(mse_pkg::DATA_W-1){1'b0}}};
  localparam word_t MAX_W = {1'b0, {(mse_pkg::DATA_W-1){1'b1}}};

  typedef struct {
    word_t value;
    logic  last;
    logic  ovf;
  } sorted_t;

  class sort_scoreboard;
    word_t   held[$];
    bit      dropped;
    sorted_t pending[$];
    int      errors;

    function void note_input(word_t v, logic l);
      word_t   ordered[$];
      word_t   key;
      sorted_t e;
      int      j;
      if (held.size() < CAPACITY) begin
        held.push_back(v);
      end else begin
        dropped = 1'b1;
      end
      if (!l) return;
      ordered = held;
      for (int i = 1; i < ordered.size(); i++) begin
        key = ordered[i];
        j = i - 1;
        while (j >= 0 && ordered[j] > key) begin
          ordered[j+1] = ordered[j];
          j--;
        end
        ordered[j+1] = key;
      end
      foreach (ordered[k]) begin
        e.value = ordered[k];
        e.last  = (k == ordered.size() - 1);
        e.ovf   = dropped;
        pending.push_back(e);
      end
      held.delete();
      dropped = 1'b0;
    endfunction

    function void check_result(word_t v, logic l, logic o);
      sorted_t e;
      if (pending.size() == 0) begin
        $error("unexpected item: sorted_value %0d", v);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (v !== e.value) begin
        $error("sorted_value: expected %0d, got %0d", e.value, v);
        errors++;
      end
      if (l !== e.last) begin
        $error("last_out: expected %0b, got %0b", e.last, l);
        errors++;
      end
      if (o !== e.ovf) begin
        $error("overflow: expected %0b, got %0b", e.ovf, o);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   idle_on;
  bit   stall_on;

  sort_scoreboard sb = new;

  mse_in_if  in_ch();
  mse_out_if out_ch();

  merge_sort_engine #(.MAX_ITEMS(CAPACITY)) uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      5, 6, 7: rand_word = word_t'(int'($urandom_range(0, 15)) - 8);
      8:       rand_word = MIN_W;
      9:       rand_word = MAX_W;
      default: rand_word = word_t'($urandom);
    endcase
  endfunction

  task automatic send_item(input word_t v, input logic l);
    if (idle_on && $urandom_range(0, 99) < 34) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 34);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= l;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(v, l);
  endtask

  task automatic send_values(input word_t vals[$]);
    foreach (vals[i]) send_item(vals[i], i == vals.size() - 1);
  endtask

  task automatic send_random_list(input int n);
    for (int i = 0; i < n; i++) send_item(rand_word(), i == n - 1);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  // receiver: check accepted results, stall at random while stall_on is set
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.sorted_value, out_ch.last_out, out_ch.overflow);
      if (rst) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(stall_on && $urandom_range(0, 99) < 34);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_MAX) begin
      @(posedge clk);
      if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("merge_sort_engine_tb: errors");
    $finish;
  end

  initial begin
    word_t dir[$];
    int    sent;
    int    lists;
    int    n;
    rst         <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    in_ch.last  <= 1'b0;
    idle_on  = 1'b1;
    stall_on = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    dir = '{MIN_W};
    send_values(dir);
    dir = '{MAX_W};
    send_values(dir);
    dir = '{MAX_W, MIN_W};
    send_values(dir);
    dir = '{word_t'(3), word_t'(-1), word_t'(3), word_t'(0), word_t'(-1), MIN_W, MAX_W,
            word_t'(3)};
    send_values(dir);
    dir = '{word_t'(1), word_t'(2), word_t'(3), word_t'(4)};
    send_values(dir);
    dir = '{word_t'(4), word_t'(3), word_t'(2), word_t'(1), word_t'(0)};
    send_values(dir);
    drain_results();

    sent  = 0;
    lists = 0;
    while (sent < RAND_ITEMS) begin
      idle_on  = !(lists >= 8 && lists < 18);
      stall_on = idle_on;
      if (lists == 3) begin
        n = CAPACITY;
      end else if (lists == 11) begin
        n = CAPACITY + 1;
      end else if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(17, CAPACITY - 1);
      end else begin
        n = $urandom_range(1, 16);
      end
      send_random_list(n);
      sent += n;
      lists++;
      if ($urandom_range(0, 3) == 0) drain_results();
    end

    drain_results();
    repeat (TAIL) @(posedge clk);
    if (sb.errors == 0) begin
      $display("merge_sort_engine_tb: clean");
    end else begin
      $display("merge_sort_engine_tb: errors");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/mse_pkg.sv
rtl/mse_if.sv
rtl/merge_sort_engine.sv
sim/merge_sort_engine_tb.sv
